@@ rtl/core/asb_pkg.sv @@
// ----------------------------------------------------------------------------
// Alpha square blitter package
// Shared constants, codes, state and interface types of the blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package asb_pkg;

  localparam int FB_WIDTH_DEF  = 64;
  localparam int FB_HEIGHT_DEF = 64;
  localparam int MAX_SIDE_DEF  = 15;

  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = 12;
  localparam int WORD_W      = 32;
  localparam int CFG_W       = 16;
  localparam int CLIP_W      = 7;
  localparam int COUNT_W     = 8;

  localparam logic [7:0] OPAQUE_LEVEL = 8'd200;
  localparam logic [7:0] FULL_ALPHA   = 8'd255;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_DRAW  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_CAMERA_OFFSET = 2'd0,
    REG_CLIP_WIDTH    = 2'd1,
    REG_CLIP_HEIGHT   = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_ALPHA,
    ST_PIX,
    ST_BL_MUL,
    ST_BL_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        start;
    logic [23:0] num;
    logic [15:0] den;
  } div_req_t;

  typedef struct packed {
    logic       busy;
    logic [7:0] quot;
  } div_rsp_t;

  // Exact floor(x / 255) for any 16-bit x below 65280, whose quotient fits 8 bits.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'b0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/asb_divider.sv @@
// ----------------------------------------------------------------------------
// Alpha divider
// Restoring divider that produces an 8-bit quotient, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module asb_divider (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire asb_pkg::div_req_t req_i,
  output asb_pkg::div_rsp_t      rsp_o
);

  logic        busy_q, busy_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] den_q, den_d;
  logic [7:0]  lo_q, lo_d;
  logic [7:0]  quot_q, quot_d;
  logic [16:0] trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    lo_d   = lo_q;
    quot_d = quot_q;
    trial  = {rem_q, lo_q[7]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 4'd8;
      rem_d  = req_i.num[23:8];
      lo_d   = req_i.num[7:0];
      den_d  = req_i.den;
      quot_d = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = 16'(trial - {1'b0, den_q});
        quot_d = {quot_q[6:0], 1'b1};
      end else begin
        rem_d  = trial[15:0];
        quot_d = {quot_q[6:0], 1'b0};
      end
      lo_d  = {lo_q[6:0], 1'b0};
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == 4'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    lo_q   <= lo_d;
    quot_q <= quot_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = quot_q;

endmodule

`default_nettype wire

@@ rtl/core/asb_fstore.sv @@
// ----------------------------------------------------------------------------
// Frame store
// Single-port 4096 x 32 pixel memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module asb_fstore (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [asb_pkg::ADDR_W-1:0] addr_i,
  input  wire logic [asb_pkg::WORD_W-1:0] wdata_i,
  output logic      [asb_pkg::WORD_W-1:0] rdata_o
);

  logic [asb_pkg::WORD_W-1:0] mem_q [asb_pkg::STORE_DEPTH];
  logic [asb_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/alpha_square_blitter_unit.sv @@
// A pixel write passes the write and done states; a pixel read passes the address,
// data and done states. A draw runs the alpha division when life is nonzero and below
// start life, then visits each covered or clipped pixel once in the pixel state; a
// blended pixel also passes the multiply and write-back states.
// One word is in flight at a time; the next is taken while a result waits.
// Reset clears control and sets the registers; the frame store is not cleared.
// ----------------------------------------------------------------------------
// Alpha square blitter unit
// Frame store with pixel access and alpha-blended square particle drawing.
// ----------------------------------------------------------------------------
`default_nettype none

module alpha_square_blitter_unit #(
  parameter int FB_WIDTH  = asb_pkg::FB_WIDTH_DEF,
  parameter int FB_HEIGHT = asb_pkg::FB_HEIGHT_DEF,
  parameter int MAX_SIDE  = asb_pkg::MAX_SIDE_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_index_i,
  input  wire logic [asb_pkg::CFG_W-1:0]   cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  op_i,
  input  wire logic [11:0]                 pixel_index_i,
  input  wire logic [31:0]                 pixel_value_i,
  input  wire logic signed [15:0]          pos_x_i,
  input  wire logic signed [15:0]          pos_y_i,
  input  wire logic [7:0]                  square_size_i,
  input  wire logic [15:0]                 life_left_i,
  input  wire logic [15:0]                 life_start_i,
  input  wire logic [23:0]                 rgb_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [31:0]                      read_value_o,
  output logic [asb_pkg::COUNT_W-1:0]      pixels_changed_o
);

  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam logic [asb_pkg::ADDR_W-1:0] FBW_A = asb_pkg::ADDR_W'(FB_WIDTH);
  localparam logic [15:0] FBW_16 = 16'(FB_WIDTH);
  localparam logic [15:0] FBH_16 = 16'(FB_HEIGHT);

  asb_pkg::state_e state_q, state_d;

  logic signed [15:0]          cam_q, cam_d;
  logic [asb_pkg::CLIP_W-1:0]  clip_w_q, clip_w_d;
  logic [asb_pkg::CLIP_W-1:0]  clip_h_q, clip_h_d;

  logic [11:0]                 idx_q, idx_d;
  logic [31:0]                 value_q, value_d;
  logic [23:0]                 rgb_q, rgb_d;
  logic [7:0]                  alpha_q, alpha_d;
  logic [12:0]                 px_q, px_d;
  logic [11:0]                 py_q, py_d;
  logic [SW-1:0]               side_q, side_d;
  logic [SW-1:0]               dx_q, dx_d;
  logic [SW-1:0]               dy_q, dy_d;
  logic [asb_pkg::ADDR_W-1:0]  addr_q, addr_d;
  logic [15:0]                 sum_q [3];
  logic [15:0]                 sum_d [3];
  logic [asb_pkg::COUNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]                 rd_q, rd_d;

  logic                        out_valid_q, out_valid_d;
  logic [31:0]                 out_rd_q, out_rd_d;
  logic [asb_pkg::COUNT_W-1:0] out_cnt_q, out_cnt_d;

  logic                        mem_we;
  logic [asb_pkg::ADDR_W-1:0]  mem_addr;
  logic [31:0]                 mem_wdata;
  logic [31:0]                 mem_rdata;

  asb_pkg::div_req_t           div_req;
  asb_pkg::div_rsp_t           div_rsp;

  logic                        in_acc;
  logic [16:0]                 xdiff, xadj;
  logic [15:0]                 yadj;
  logic [3:0]                  side_raw;
  logic [15:0]                 rx, ry, wlim, hlim;
  logic                        in_view;
  logic [asb_pkg::ADDR_W-1:0]  pix_addr;
  logic                        last_col, last_row, advance;
  logic [asb_pkg::COUNT_W-1:0] cnt_inc;

  asb_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  asb_fstore u_fstore (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign in_ready_o = (state_q == asb_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    xdiff    = {pos_x_i[15], pos_x_i} - {cam_q[15], cam_q};
    xadj     = xdiff + (xdiff[16] ? 17'd15 : 17'd0);
    yadj     = pos_y_i + (pos_y_i[15] ? 16'd15 : 16'd0);
    side_raw = square_size_i[7:4];
    rx       = {{3{px_q[12]}}, px_q} + {{(16-SW){1'b0}}, dx_q};
    ry       = {{4{py_q[11]}}, py_q} + {{(16-SW){1'b0}}, dy_q};
    wlim     = ({9'b0, clip_w_q} < FBW_16) ? {9'b0, clip_w_q} : FBW_16;
    hlim     = ({9'b0, clip_h_q} < FBH_16) ? {9'b0, clip_h_q} : FBH_16;
    in_view  = !rx[15] && !ry[15] && (rx < wlim) && (ry < hlim);
    pix_addr = ({5'b0, ry[6:0]} * FBW_A) + {5'b0, rx[6:0]};
    last_col = (dx_q == side_q - SW'(1));
    last_row = (dy_q == side_q - SW'(1));
    cnt_inc  = (cnt_q == {asb_pkg::COUNT_W{1'b1}}) ? cnt_q : cnt_q + 1'b1;
  end

  always_comb begin
    cam_d    = cam_q;
    clip_w_d = clip_w_q;
    clip_h_d = clip_h_q;
    if (cfg_we_i) begin
      case (asb_pkg::cfg_reg_e'(cfg_index_i))
        asb_pkg::REG_CAMERA_OFFSET: cam_d    = cfg_data_i;
        asb_pkg::REG_CLIP_WIDTH:    clip_w_d = cfg_data_i[asb_pkg::CLIP_W-1:0];
        asb_pkg::REG_CLIP_HEIGHT:   clip_h_d = cfg_data_i[asb_pkg::CLIP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    value_d     = value_q;
    rgb_d       = rgb_q;
    alpha_d     = alpha_q;
    px_d        = px_q;
    py_d        = py_q;
    side_d      = side_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    addr_d      = addr_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    rd_d        = rd_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rd_d    = out_rd_q;
    out_cnt_d   = out_cnt_q;
    mem_we      = 1'b0;
    mem_addr    = idx_q;
    mem_wdata   = value_q;
    div_req     = '{start: 1'b0, num: {life_left_i, 8'b0} - {8'b0, life_left_i},
                    den: life_start_i};
    advance     = 1'b0;

    case (state_q)
      asb_pkg::ST_IDLE: begin
        if (in_acc) begin
          idx_d   = pixel_index_i;
          value_d = pixel_value_i;
          rgb_d   = rgb_i;
          px_d    = xadj[16:4];
          py_d    = yadj[15:4];
          dx_d    = '0;
          dy_d    = '0;
          cnt_d   = '0;
          rd_d    = '0;
          if (side_raw == 4'd0) begin
            side_d = SW'(1);
          end else if (int'(side_raw) > MAX_SIDE) begin
            side_d = SW'(MAX_SIDE);
          end else begin
            side_d = SW'(side_raw);
          end
          case (asb_pkg::op_e'(op_i))
            asb_pkg::OP_WRITE: state_d = asb_pkg::ST_WRITE;
            asb_pkg::OP_READ:  state_d = asb_pkg::ST_RD_ADDR;
            asb_pkg::OP_DRAW: begin
              if (life_left_i == 16'd0) begin
                state_d = asb_pkg::ST_DONE;
              end else if (life_left_i >= life_start_i) begin
                alpha_d = asb_pkg::FULL_ALPHA;
                state_d = asb_pkg::ST_PIX;
              end else begin
                div_req.start = 1'b1;
                state_d       = asb_pkg::ST_ALPHA;
              end
            end
            default: state_d = asb_pkg::ST_DONE;
          endcase
        end
      end
      asb_pkg::ST_WRITE: begin
        mem_we  = 1'b1;
        state_d = asb_pkg::ST_DONE;
      end
      asb_pkg::ST_RD_ADDR: begin
        state_d = asb_pkg::ST_RD_DATA;
      end
      asb_pkg::ST_RD_DATA: begin
        rd_d    = mem_rdata;
        state_d = asb_pkg::ST_DONE;
      end
      asb_pkg::ST_ALPHA: begin
        if (!div_rsp.busy) begin
          alpha_d = div_rsp.quot;
          state_d = (div_rsp.quot == 8'd0) ? asb_pkg::ST_DONE : asb_pkg::ST_PIX;
        end
      end
      asb_pkg::ST_PIX: begin
        mem_addr = pix_addr;
        if (!in_view) begin
          advance = 1'b1;
        end else if (alpha_q >= asb_pkg::OPAQUE_LEVEL) begin
          mem_we    = 1'b1;
          mem_wdata = {alpha_q, rgb_q};
          cnt_d     = cnt_inc;
          advance   = 1'b1;
        end else begin
          addr_d  = pix_addr;
          state_d = asb_pkg::ST_BL_MUL;
        end
      end
      asb_pkg::ST_BL_MUL: begin
        for (int c = 0; c < 3; c++) begin
          sum_d[c] = 16'(rgb_q[8*c +: 8]) * 16'(alpha_q)
                   + 16'(mem_rdata[8*c +: 8]) * 16'(asb_pkg::FULL_ALPHA - alpha_q);
        end
        state_d = asb_pkg::ST_BL_WR;
      end
      asb_pkg::ST_BL_WR: begin
        mem_we    = 1'b1;
        mem_addr  = addr_q;
        mem_wdata = {8'hFF, asb_pkg::div255(sum_q[2]), asb_pkg::div255(sum_q[1]),
                     asb_pkg::div255(sum_q[0])};
        cnt_d     = cnt_inc;
        advance   = 1'b1;
      end
      asb_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_rd_d    = rd_q;
          out_cnt_d   = cnt_q;
          state_d     = asb_pkg::ST_IDLE;
        end
      end
      default: state_d = asb_pkg::ST_IDLE;
    endcase

    if (advance) begin
      if (last_col) begin
        dx_d = '0;
        if (last_row) begin
          state_d = asb_pkg::ST_DONE;
        end else begin
          dy_d    = dy_q + SW'(1);
          state_d = asb_pkg::ST_PIX;
        end
      end else begin
        dx_d    = dx_q + SW'(1);
        state_d = asb_pkg::ST_PIX;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= asb_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      cam_q       <= '0;
      clip_w_q    <= asb_pkg::CLIP_W'(64);
      clip_h_q    <= asb_pkg::CLIP_W'(64);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cam_q       <= cam_d;
      clip_w_q    <= clip_w_d;
      clip_h_q    <= clip_h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    value_q   <= value_d;
    rgb_q     <= rgb_d;
    alpha_q   <= alpha_d;
    px_q      <= px_d;
    py_q      <= py_d;
    side_q    <= side_d;
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    addr_q    <= addr_d;
    sum_q     <= sum_d;
    cnt_q     <= cnt_d;
    rd_q      <= rd_d;
    out_rd_q  <= out_rd_d;
    out_cnt_q <= out_cnt_d;
  end

  assign out_valid_o      = out_valid_q;
  assign read_value_o     = out_rd_q;
  assign pixels_changed_o = out_cnt_q;

endmodule

`default_nettype wire

@@ rtl/core/asb_checker.sv @@
// ----------------------------------------------------------------------------
// Alpha square blitter checker
// Port-level assertions on the blitter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module asb_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [31:0]                 read_value_o,
  input wire logic [asb_pkg::COUNT_W-1:0] pixels_changed_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_value_o)
      && $stable(pixels_changed_o))
    else $error("Result word changed or dropped while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input taken again right after a word was accepted.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (read_value_o == 32'd0) || (pixels_changed_o == '0))
    else $error("Result carries both read data and a pixel count.");

endmodule

bind alpha_square_blitter_unit asb_checker u_asb_checker (.*);

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Alpha square blitter testbench
// Sends pixel writes, pixel reads and particle draws over valid/ready and keeps
// a shadow frame store that predicts every result word. Results are compared
// field by field in order. The store is filled by opaque draws first, so no
// read or blend ever touches an unwritten entry. Directed corner cases come
// next, then random traffic under several view settings with random idling
// on both sides and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int FB_W         = asb_pkg::FB_WIDTH_DEF;
  localparam int FB_H         = asb_pkg::FB_HEIGHT_DEF;
  localparam int SIDE_MAX     = asb_pkg::MAX_SIDE_DEF;
  localparam int PHASE_WORDS  = 235;
  localparam int LIMIT_CYCLES = 5_000_000;

  typedef struct {
    asb_pkg::op_e                op;
    logic [asb_pkg::ADDR_W-1:0]  index;
    logic [asb_pkg::WORD_W-1:0]  value;
    logic signed [15:0]          x;
    logic signed [15:0]          y;
    logic [7:0]                  size;
    logic [15:0]                 life;
    logic [15:0]                 start;
    logic [23:0]                 rgb;
  } blit_word_t;

  typedef struct {
    logic [asb_pkg::WORD_W-1:0]  read_value;
    logic [asb_pkg::COUNT_W-1:0] changed;
  } blit_result_t;

  logic                        clk_i     = 1'b0;
  logic                        rst_ni    = 1'b0;
  logic                        cfg_we    = 1'b0;
  logic [1:0]                  cfg_index = asb_pkg::REG_CAMERA_OFFSET;
  logic [asb_pkg::CFG_W-1:0]   cfg_data  = '0;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  logic [1:0]                  op_d      = asb_pkg::OP_NONE;
  logic [11:0]                 index_d   = '0;
  logic [31:0]                 value_d   = '0;
  logic signed [15:0]          x_d       = '0;
  logic signed [15:0]          y_d       = '0;
  logic [7:0]                  size_d    = '0;
  logic [15:0]                 life_d    = '0;
  logic [15:0]                 start_d   = '0;
  logic [23:0]                 rgb_d     = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [31:0]                 read_value;
  logic [asb_pkg::COUNT_W-1:0] changed;

  logic [asb_pkg::WORD_W-1:0]  shadow_frame [asb_pkg::STORE_DEPTH];
  logic signed [15:0]          cam_q    = '0;
  logic [asb_pkg::CLIP_W-1:0]  clip_w_q = 7'd64;
  logic [asb_pkg::CLIP_W-1:0]  clip_h_q = 7'd64;
  blit_result_t                pending_results [$];
  int                          mismatch_cnt = 0;
  int                          hold_cycles  = 0;
  bit                          src_idle_en  = 1'b0;
  bit                          snk_idle_en  = 1'b0;

  alpha_square_blitter_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .op_i             (op_d),
    .pixel_index_i    (index_d),
    .pixel_value_i    (value_d),
    .pos_x_i          (x_d),
    .pos_y_i          (y_d),
    .square_size_i    (size_d),
    .life_left_i      (life_d),
    .life_start_i     (start_d),
    .rgb_i            (rgb_d),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .read_value_o     (read_value),
    .pixels_changed_o (changed)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] mix_channel(logic [7:0] src, logic [7:0] dst,
                                             int unsigned a);
    int unsigned t;
    t = (src * a + dst * (255 - a)) / 255;
    return 8'(t);
  endfunction

  function automatic blit_result_t predict_blit(blit_word_t w);
    blit_result_t r;
    int unsigned  alpha;
    int unsigned  cnt;
    int           px, py, side, wlim, hlim, rx, ry, addr;
    logic [31:0]  d;
    r.read_value = '0;
    r.changed    = '0;
    cnt          = 0;
    case (w.op)
      asb_pkg::OP_WRITE: shadow_frame[w.index] = w.value;
      asb_pkg::OP_READ:  r.read_value = shadow_frame[w.index];
      asb_pkg::OP_DRAW: begin
        if (w.life != 0) begin
          if (w.start == 0) begin
            alpha = 255;
          end else begin
            alpha = (32'(w.life) * 32'd255) / 32'(w.start);
            if (alpha > 255) alpha = 255;
          end
          px   = (int'(w.x) - int'(cam_q)) / 16;
          py   = int'(w.y) / 16;
          side = int'(w.size[7:4]);
          if (side < 1) side = 1;
          if (side > SIDE_MAX) side = SIDE_MAX;
          wlim = (int'(clip_w_q) < FB_W) ? int'(clip_w_q) : FB_W;
          hlim = (int'(clip_h_q) < FB_H) ? int'(clip_h_q) : FB_H;
          if (alpha > 0) begin
            for (int dy = 0; dy < side; dy++) begin
              ry = py + dy;
              if (ry < 0 || ry >= hlim) continue;
              for (int dx = 0; dx < side; dx++) begin
                rx = px + dx;
                if (rx < 0 || rx >= wlim) continue;
                addr = (ry * FB_W + rx) % asb_pkg::STORE_DEPTH;
                if (alpha >= asb_pkg::OPAQUE_LEVEL) begin
                  shadow_frame[addr] = {8'(alpha), w.rgb};
                end else begin
                  d = shadow_frame[addr];
                  shadow_frame[addr] = {8'hFF,
                                        mix_channel(w.rgb[23:16], d[23:16], alpha),
                                        mix_channel(w.rgb[15:8], d[15:8], alpha),
                                        mix_channel(w.rgb[7:0], d[7:0], alpha)};
                end
                if (cnt < 255) cnt++;
              end
            end
          end
          r.changed = 8'(cnt);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic blit_word_t noise_word();
    blit_word_t w;
    w.op    = asb_pkg::op_e'($urandom_range(0, 3));
    w.index = 12'($urandom);
    w.value = $urandom;
    w.x     = 16'($urandom);
    w.y     = 16'($urandom);
    w.size  = 8'($urandom);
    w.life  = 16'($urandom);
    w.start = 16'($urandom);
    w.rgb   = 24'($urandom);
    return w;
  endfunction

  function automatic blit_word_t draw_word(int x, int y, int size, int life,
                                           int start, int rgb);
    blit_word_t w;
    w       = noise_word();
    w.op    = asb_pkg::OP_DRAW;
    w.x     = 16'(x);
    w.y     = 16'(y);
    w.size  = 8'(size);
    w.life  = 16'(life);
    w.start = 16'(start);
    w.rgb   = 24'(rgb);
    return w;
  endfunction

  function automatic blit_word_t pixel_word(asb_pkg::op_e op, int index,
                                            logic [31:0] value);
    blit_word_t w;
    w       = noise_word();
    w.op    = op;
    w.index = 12'(index);
    w.value = value;
    return w;
  endfunction

  function automatic blit_word_t random_word();
    blit_word_t w;
    int         roll;
    w    = noise_word();
    roll = $urandom_range(0, 99);
    if (roll < 22) w.op = asb_pkg::OP_WRITE;
    else if (roll < 40) w.op = asb_pkg::OP_READ;
    else if (roll < 95) w.op = asb_pkg::OP_DRAW;
    else w.op = asb_pkg::OP_NONE;
    if ($urandom_range(0, 9) != 0) begin
      w.x = 16'(int'(cam_q) + int'($urandom_range(0, 1279)) - 256);
      w.y = 16'(int'($urandom_range(0, 1279)) - 256);
    end
    if ($urandom_range(0, 99) < 85) w.size = 8'($urandom_range(0, 79));
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      w.start = 16'($urandom_range(1, 65535));
      w.life  = w.start;
    end else if (roll < 70) begin
      w.start = 16'($urandom_range(1, 65535));
      w.life  = 16'($urandom_range(1, w.start));
    end else if (roll < 78) begin
      w.life = '0;
    end else if (roll < 86) begin
      w.start = '0;
      if (w.life == 0) w.life = 16'd1;
    end
    return w;
  endfunction

  function automatic int idle_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] exp,
                                 input logic [31:0] got);
    if (mismatch_cnt < 50) begin
      $display("MISMATCH at %0t: %s expected %h, got %h", $realtime, what, exp, got);
    end
    mismatch_cnt++;
  endtask

  task automatic send_word(input blit_word_t w);
    int gap;
    gap = (src_idle_en && $urandom_range(0, 1) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    op_d     <= w.op;
    index_d  <= w.index;
    value_d  <= w.value;
    x_d      <= w.x;
    y_d      <= w.y;
    size_d   <= w.size;
    life_d   <= w.life;
    start_d  <= w.start;
    rgb_d    <= w.rgb;
    do @(posedge clk_i); while (in_ready !== 1'b1);
    pending_results.push_back(predict_blit(w));
  endtask

  task automatic drain(input int settle);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_view(input int cam, input int cw, input int ch);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= asb_pkg::REG_CAMERA_OFFSET;
    cfg_data  <= 16'(cam);
    @(posedge clk_i);
    cfg_index <= asb_pkg::REG_CLIP_WIDTH;
    cfg_data  <= 16'(7'(cw));
    @(posedge clk_i);
    cfg_index <= asb_pkg::REG_CLIP_HEIGHT;
    cfg_data  <= 16'(7'(ch));
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    cam_q    = 16'(cam);
    clip_w_q = 7'(cw);
    clip_h_q = 7'(ch);
  endtask

  // Opaque 15x15 squares cover the whole visible frame, which is every store word.
  task automatic fill_frame();
    for (int j = 0; j < 5; j++) begin
      for (int i = 0; i < 5; i++) begin
        send_word(draw_word(i * 240, j * 240, 8'hF0, 1, 1, $urandom));
      end
    end
  endtask

  task automatic test_pixel_access();
    send_word(pixel_word(asb_pkg::OP_WRITE, 0, 32'h0000_0000));
    send_word(pixel_word(asb_pkg::OP_WRITE, 4095, 32'hFFFF_FFFF));
    send_word(pixel_word(asb_pkg::OP_READ, 0, $urandom));
    send_word(pixel_word(asb_pkg::OP_READ, 4095, $urandom));
    send_word(pixel_word(asb_pkg::OP_NONE, 1, $urandom));
    send_word(pixel_word(asb_pkg::OP_WRITE, 4095, 32'h5A5A_A5A5));
    send_word(pixel_word(asb_pkg::OP_READ, 4095, $urandom));
  endtask

  task automatic test_draw_corners();
    send_word(draw_word(16, 16, 8'h30, 0, 5, $urandom));
    send_word(draw_word(0, 0, 8'h00, 1, 0, 24'h123456));
    send_word(draw_word(80, 80, 8'h20, 200, 255, $urandom));
    send_word(draw_word(80, 80, 8'h20, 199, 255, 24'hFFFFFF));
    send_word(draw_word(160, 160, 8'hF0, 1, 65535, $urandom));
    send_word(draw_word(960, 960, 8'hFF, 65535, 1, 24'h000000));
    send_word(draw_word(-8, -24, 8'h3F, 100, 300, $urandom));
    send_word(draw_word(32767, -32768, 8'hFF, 9, 9, $urandom));
    send_word(draw_word(-32768, 32767, 8'hFF, 9, 9, $urandom));
    send_word(pixel_word(asb_pkg::OP_READ, 0, $urandom));
    send_word(pixel_word(asb_pkg::OP_READ, 5 * FB_W + 5, $urandom));
  endtask

  task automatic test_view_registers();
    drain(16);
    set_view(-32768, 0, 0);
    send_word(draw_word(0, 0, 8'hF0, 7, 7, $urandom));
    drain(16);
    set_view(32767, 127, 127);
    send_word(draw_word(32767, 0, 8'h40, 50, 100, $urandom));
    send_word(draw_word(-32768, 0, 8'h40, 50, 100, $urandom));
    drain(16);
    set_view(16, 1, 1);
    send_word(draw_word(16, 0, 8'h50, 3, 3, $urandom));
    drain(16);
    set_view(-40, 64, 63);
    send_word(draw_word(0, 62 * 16, 8'h30, 120, 200, $urandom));
  endtask

  task automatic test_backpressure();
    drain(16);
    set_view(0, 64, 64);
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    hold_cycles = 400;
    repeat (12) send_word(random_word());
    drain(16);
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 6; p++) begin
      drain(16);
      case (p)
        0: set_view(0, 64, 64);
        1: set_view(-32768, 127, 127);
        2: set_view(32767, 64, 64);
        3: set_view($urandom, $urandom_range(1, 16), $urandom_range(1, 16));
        4: set_view($urandom, $urandom_range(0, 127), $urandom_range(0, 127));
        default: set_view($urandom_range(0, 1280) - 640, 64, 64);
      endcase
      src_idle_en = (p != 0 && p != 2);
      snk_idle_en = (p != 0 && p != 1);
      repeat (PHASE_WORDS) send_word(random_word());
    end
  endtask

  initial begin : result_sink
    blit_result_t got;
    blit_result_t exp;
    bit           rdy;
    int           stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid === 1'b1 && out_ready) begin
        got.read_value = read_value;
        got.changed    = changed;
        if (pending_results.size() == 0) begin
          report_mismatch("result word with nothing pending", '0, got.read_value);
        end else begin
          exp = pending_results.pop_front();
          if (got.read_value !== exp.read_value) begin
            report_mismatch("read_value", exp.read_value, got.read_value);
          end
          if (got.changed !== exp.changed) begin
            report_mismatch("pixels_changed", 32'(exp.changed), 32'(got.changed));
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (snk_idle_en && $urandom_range(0, 3) == 0) begin
        stall_left = idle_len() - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready <= rdy;
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("Mismatches found");
    $finish;
  end

  initial begin : run_tests
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fill_frame();
    test_pixel_access();
    test_draw_corners();
    test_view_registers();
    test_backpressure();
    test_random_traffic();
    drain(700);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
